// ===== design/fea_pkg.sv =====
package fea_pkg;

    // request operation codes carried in s_tuser
    typedef enum logic [1:0] {
        OP_READ_ENTRY  = 2'd0,
        OP_WRITE_ENTRY = 2'd1,
        OP_LOAD_BYTE   = 2'd2,
        OP_READ_BYTE   = 2'd3
    } op_e_t;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 16;
    localparam int VAL_W    = 32;
    localparam int CFG_IDX_W = 3;

    // widest byte offset plus entry length (4 * 65535 + 4)
    localparam int OFF_W = 19;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BEYOND = 2'd2;

    // entry format codes, any other code is treated as 32 bit
    localparam logic [1:0] FMT_12 = 2'd0;
    localparam logic [1:0] FMT_16 = 2'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_FORMAT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CLUSTER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAD_THRESHOLD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE_STORED = 3'd5;

    // reset values of the configuration registers
    localparam logic [1:0]  RST_ENTRY_FORMAT    = 2'd0;
    localparam logic [15:0] RST_FIRST_CLUSTER   = 16'd2;
    localparam logic [15:0] RST_CLUSTER_LIMIT   = 16'hffff;
    localparam logic [27:0] RST_BAD_THRESHOLD   = 28'd4087;
    localparam logic [31:0] RST_END_MARKER      = 32'h0fff_ffff;
    localparam logic [15:0] RST_END_CODE_STORED = 16'h0fff;

endpackage

// ===== design/fea_ram.sv =====
module fea_ram #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  logic              aclk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [7:0]        wdata,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];

    // single byte port, registered read data
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ===== design/fat_entry_access.sv =====
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    s_tdata: entry_index, raw_address, write_value; s_tuser: op
// m_        out  m_tvalid/m_tready    m_tdata: read_value; m_tuser: status
// cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One request at a time; the byte store has a single port, one byte per cycle.
// FAT12 and FAT32 entry writes are a read-modify-write of one byte; FAT16 entry
// writes and raw loads write the store directly, and errors skip the store.
// Reset clears control and configuration; store contents are undefined until
// written. A stalled result holds in the output register until m_tready.
module fat_entry_access #(
    parameter int STORE_BYTES = 65536
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input requests
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [63:0]                     s_tdata,  // entry_index, raw_address, write_value
    input  logic [fea_pkg::OP_W-1:0]        s_tuser,  // op
    // results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fea_pkg::VAL_W-1:0]       m_tdata,  // read_value
    output logic [fea_pkg::STATUS_W-1:0]    m_tuser,  // status
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fea_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);

    import fea_pkg::*;

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int LIM_W  = (ADDR_W + 1 > OFF_W) ? ADDR_W + 1 : OFF_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RMW_RD,
        S_RMW_WAIT,
        S_WRITE,
        S_READ,
        S_POST,
        S_OUT
    } state_t;

    state_t                 state_reg, state_next;
    op_e_t                  op_reg, op_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [15:0]            addr_reg, addr_next;
    logic [VAL_W-1:0]       wv_reg, wv_next;
    logic [ADDR_W-1:0]      base_reg, base_next;
    logic [2:0]             nbytes_reg, nbytes_next;
    logic [2:0]             cnt_reg, cnt_next;
    logic                   pend_reg, pend_next;
    logic [1:0]             lane_reg, lane_next;
    logic [VAL_W-1:0]       acc_reg, acc_next;
    logic [STATUS_W-1:0]    stat_reg, stat_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [VAL_W-1:0]       m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]    m_tuser_reg, m_tuser_next;

    logic [1:0]             fmt_reg, fmt_next;
    logic [15:0]            first_reg, first_next;
    logic [15:0]            limit_reg, limit_next;
    logic [27:0]            thresh_reg, thresh_next;
    logic [31:0]            marker_reg, marker_next;
    logic [15:0]            endcode_reg, endcode_next;

    // store port
    logic                   ram_en;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_addr;
    logic [7:0]             ram_wdata;
    logic [7:0]             ram_rdata;

    // offset and bound check
    logic                   is12, is16;
    logic [OFF_W-1:0]       off;
    logic [2:0]             len;
    logic [LIM_W-1:0]       off_ext;
    logic [LIM_W-1:0]       end_ext;
    logic                   fits;
    logic                   out_of_range;
    logic [STATUS_W-1:0]    chk_status;

    // write value preparation and read extraction
    logic [VAL_W-1:0]       wsub;
    logic [VAL_W-1:0]       wprep;
    logic [27:0]            entry_v;
    logic [1:0]             rmw_ofs;

    fea_ram #(
        .DEPTH  (STORE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign is12 = (fmt_reg == FMT_12);
    assign is16 = (fmt_reg == FMT_16);

    // byte offset and length of the access
    always_comb begin
        if (op_reg == OP_LOAD_BYTE || op_reg == OP_READ_BYTE) begin
            off = OFF_W'(addr_reg);
            len = 3'd1;
        end else if (is12) begin
            off = OFF_W'(idx_reg) + OFF_W'(idx_reg[IDX_W-1:1]);
            len = 3'd2;
        end else if (is16) begin
            off = OFF_W'({idx_reg, 1'b0});
            len = 3'd2;
        end else begin
            off = OFF_W'({idx_reg, 2'b00});
            len = 3'd4;
        end
    end

    assign off_ext      = LIM_W'(off);
    assign end_ext      = off_ext + LIM_W'(len);
    assign fits         = (end_ext <= LIM_W'(STORE_BYTES));
    assign out_of_range = (idx_reg < first_reg) || (idx_reg >= limit_reg);

    always_comb begin
        if (op_reg == OP_READ_ENTRY && out_of_range) begin
            chk_status = ST_RANGE;
        end else if (!fits) begin
            chk_status = ST_BEYOND;
        end else begin
            chk_status = ST_OK;
        end
    end

    // entry value laid out as bytes, old nibbles merged later
    assign wsub = (wv_reg == marker_reg) ? VAL_W'(endcode_reg) : wv_reg;

    always_comb begin
        if (op_reg == OP_LOAD_BYTE) begin
            wprep = VAL_W'(wv_reg[7:0]);
        end else if (is12) begin
            if (idx_reg[0]) begin
                wprep = VAL_W'({wsub[11:0], 4'h0});
            end else begin
                wprep = VAL_W'(wsub[11:0]);
            end
        end else if (is16) begin
            wprep = VAL_W'(wsub[15:0]);
        end else begin
            wprep = {4'h0, wv_reg[27:0]};
        end
    end

    // byte holding the nibble that a write keeps
    always_comb begin
        if (is12) begin
            rmw_ofs = idx_reg[0] ? 2'd0 : 2'd1;
        end else begin
            rmw_ofs = 2'd3;
        end
    end

    // entry value from gathered bytes
    always_comb begin
        if (is12) begin
            entry_v = idx_reg[0] ? 28'(acc_reg[15:4]) : 28'(acc_reg[11:0]);
        end else if (is16) begin
            entry_v = 28'(acc_reg[15:0]);
        end else begin
            entry_v = acc_reg[27:0];
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        addr_next     = addr_reg;
        wv_next       = wv_reg;
        base_next     = base_reg;
        nbytes_next   = nbytes_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        lane_next     = lane_reg;
        acc_next      = acc_reg;
        stat_next     = stat_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = base_reg + ADDR_W'(cnt_reg);
        ram_wdata = acc_reg[{cnt_reg[1:0], 3'b000} +: 8];

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = op_e_t'(s_tuser);
                    idx_next   = s_tdata[15:0];
                    addr_next  = s_tdata[31:16];
                    wv_next    = s_tdata[63:32];
                    state_next = S_CHECK;
                end
            end

            S_CHECK: begin
                base_next   = off_ext[ADDR_W-1:0];
                nbytes_next = len;
                cnt_next    = 3'd0;
                pend_next   = 1'b0;
                stat_next   = chk_status;
                if (op_reg == OP_WRITE_ENTRY || op_reg == OP_LOAD_BYTE) begin
                    acc_next = wprep;
                end else begin
                    acc_next = '0;
                end
                if (chk_status != ST_OK) begin
                    state_next = S_POST;
                end else begin
                    case (op_reg)
                        OP_READ_ENTRY:  state_next = S_READ;
                        OP_READ_BYTE:   state_next = S_READ;
                        OP_LOAD_BYTE:   state_next = S_WRITE;
                        OP_WRITE_ENTRY: state_next = is16 ? S_WRITE : S_RMW_RD;
                        default:        state_next = S_POST;
                    endcase
                end
            end

            // fetch the byte whose upper or lower nibble survives
            S_RMW_RD: begin
                ram_en     = 1'b1;
                ram_addr   = base_reg + ADDR_W'(rmw_ofs);
                state_next = S_RMW_WAIT;
            end

            S_RMW_WAIT: begin
                if (is12 && idx_reg[0]) begin
                    acc_next[3:0] = ram_rdata[3:0];
                end else if (is12) begin
                    acc_next[15:12] = ram_rdata[7:4];
                end else begin
                    acc_next[31:28] = ram_rdata[7:4];
                end
                state_next = S_WRITE;
            end

            // one byte per cycle, lowest first
            S_WRITE: begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == nbytes_reg - 3'd1) begin
                    state_next = S_POST;
                end
            end

            // issue byte reads back to back, gather each byte in the cycle after its read
            S_READ: begin
                if (pend_reg) begin
                    acc_next[{lane_reg, 3'b000} +: 8] = ram_rdata;
                end
                if (cnt_reg < nbytes_reg) begin
                    ram_en    = 1'b1;
                    cnt_next  = cnt_reg + 3'd1;
                    pend_next = 1'b1;
                    lane_next = cnt_reg[1:0];
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = S_POST;
                    end
                end
            end

            // threshold compare and result register
            S_POST: begin
                if (stat_reg != ST_OK) begin
                    m_tdata_next = '0;
                end else if (op_reg == OP_READ_BYTE) begin
                    m_tdata_next = VAL_W'(acc_reg[7:0]);
                end else if (op_reg == OP_READ_ENTRY) begin
                    if (entry_v >= thresh_reg) begin
                        m_tdata_next = marker_reg;
                    end else begin
                        m_tdata_next = VAL_W'(entry_v);
                    end
                end else begin
                    m_tdata_next = '0;
                end
                m_tuser_next  = stat_reg;
                m_tvalid_next = 1'b1;
                state_next    = S_OUT;
            end

            S_OUT: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // configuration registers
    always_comb begin
        fmt_next     = fmt_reg;
        first_next   = first_reg;
        limit_next   = limit_reg;
        thresh_next  = thresh_reg;
        marker_next  = marker_reg;
        endcode_next = endcode_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ENTRY_FORMAT:    fmt_next     = cfg_data[1:0];
                CFG_FIRST_CLUSTER:   first_next   = cfg_data[15:0];
                CFG_CLUSTER_LIMIT:   limit_next   = cfg_data[15:0];
                CFG_BAD_THRESHOLD:   thresh_next  = cfg_data[27:0];
                CFG_END_MARKER:      marker_next  = cfg_data;
                CFG_END_CODE_STORED: endcode_next = cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            op_reg       <= OP_READ_ENTRY;
            idx_reg      <= '0;
            addr_reg     <= '0;
            wv_reg       <= '0;
            base_reg     <= '0;
            nbytes_reg   <= '0;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            lane_reg     <= '0;
            acc_reg      <= '0;
            stat_reg     <= ST_OK;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= ST_OK;
            fmt_reg      <= RST_ENTRY_FORMAT;
            first_reg    <= RST_FIRST_CLUSTER;
            limit_reg    <= RST_CLUSTER_LIMIT;
            thresh_reg   <= RST_BAD_THRESHOLD;
            marker_reg   <= RST_END_MARKER;
            endcode_reg  <= RST_END_CODE_STORED;
        end else begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            idx_reg      <= idx_next;
            addr_reg     <= addr_next;
            wv_reg       <= wv_next;
            base_reg     <= base_next;
            nbytes_reg   <= nbytes_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            lane_reg     <= lane_next;
            acc_reg      <= acc_next;
            stat_reg     <= stat_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
            fmt_reg      <= fmt_next;
            first_reg    <= first_next;
            limit_reg    <= limit_next;
            thresh_reg   <= thresh_next;
            marker_reg   <= marker_next;
            endcode_reg  <= endcode_next;
        end
    end

endmodule

// ===== tb/fea_checker.sv =====
module fat_access_checker #(
    parameter int STORE_BYTES = 65536
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [63:0]                    s_tdata,   // entry_index, raw_address, write_value
    input  logic [fea_pkg::OP_W-1:0]       s_tuser,   // op
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [fea_pkg::VAL_W-1:0]      m_tdata,   // read_value
    input  logic [fea_pkg::STATUS_W-1:0]   m_tuser,   // status
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [fea_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data,
    output int                             mismatches,
    output int                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import fea_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0]    value;
        logic [STATUS_W-1:0] status;
    } fat_result_t;

    // shadow of the byte store and the register file
    logic [7:0]  fat_image [0:STORE_BYTES-1];
    logic [1:0]  cfg_format;
    logic [15:0] cfg_first;
    logic [15:0] cfg_limit;
    logic [27:0] cfg_threshold;
    logic [31:0] cfg_marker;
    logic [15:0] cfg_end_code;

    fat_result_t expected_results [$];
    fat_result_t oldest;
    int          results_seen;

    task automatic report_failure(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endtask

    // byte offset and length of one entry in the current format
    function automatic int entry_offset(input logic [15:0] idx, output int len);
        case (cfg_format)
            FMT_12: begin
                len = 2;
                return int'(idx) + int'(idx >> 1);
            end
            FMT_16: begin
                len = 2;
                return 2 * int'(idx);
            end
            default: begin
                len = 4;
                return 4 * int'(idx);
            end
        endcase
    endfunction

    // result of one request, with its effect on the shadow store
    function automatic fat_result_t access_fat(input op_e_t op, input logic [15:0] idx,
                                               input logic [15:0] addr,
                                               input logic [31:0] wv);
        fat_result_t res;
        int          off;
        int          len;
        logic [31:0] entry;
        logic [31:0] val;
        res.value  = '0;
        res.status = ST_OK;
        case (op)
            OP_READ_ENTRY: begin
                off = entry_offset(idx, len);
                if (idx < cfg_first || idx >= cfg_limit) begin
                    res.status = ST_RANGE;
                end else if (off + len > STORE_BYTES) begin
                    res.status = ST_BEYOND;
                end else begin
                    case (cfg_format)
                        FMT_12: begin
                            if (idx[0])
                                entry = {20'b0, fat_image[off+1], fat_image[off][7:4]};
                            else
                                entry = {20'b0, fat_image[off+1][3:0], fat_image[off]};
                        end
                        FMT_16: entry = {16'b0, fat_image[off+1], fat_image[off]};
                        default: entry = {4'b0, fat_image[off+3][3:0], fat_image[off+2],
                                          fat_image[off+1], fat_image[off]};
                    endcase
                    if (entry >= {4'b0, cfg_threshold}) entry = cfg_marker;
                    res.value = entry;
                end
            end
            OP_WRITE_ENTRY: begin
                off = entry_offset(idx, len);
                if (off + len > STORE_BYTES) begin
                    res.status = ST_BEYOND;
                end else begin
                    // the 12 and 16 bit formats store their own end code
                    val = wv;
                    if ((cfg_format == FMT_12 || cfg_format == FMT_16) && wv == cfg_marker)
                        val = {16'b0, cfg_end_code};
                    case (cfg_format)
                        FMT_12: begin
                            if (idx[0]) begin
                                fat_image[off]   = {val[3:0], fat_image[off][3:0]};
                                fat_image[off+1] = val[11:4];
                            end else begin
                                fat_image[off]   = val[7:0];
                                fat_image[off+1] = {fat_image[off+1][7:4], val[11:8]};
                            end
                        end
                        FMT_16: begin
                            fat_image[off]   = val[7:0];
                            fat_image[off+1] = val[15:8];
                        end
                        default: begin
                            // top nibble of the last byte is kept
                            fat_image[off]   = val[7:0];
                            fat_image[off+1] = val[15:8];
                            fat_image[off+2] = val[23:16];
                            fat_image[off+3] = {fat_image[off+3][7:4], val[27:24]};
                        end
                    endcase
                end
            end
            OP_LOAD_BYTE: begin
                if (int'(addr) < STORE_BYTES) fat_image[addr] = wv[7:0];
                else res.status = ST_BEYOND;
            end
            default: begin
                if (int'(addr) < STORE_BYTES) res.value = {24'b0, fat_image[addr]};
                else res.status = ST_BEYOND;
            end
        endcase
        return res;
    endfunction

    // register writes, result compare, then new requests
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STORE_BYTES; i++) fat_image[i] = 8'h00;
            cfg_format    = RST_ENTRY_FORMAT;
            cfg_first     = RST_FIRST_CLUSTER;
            cfg_limit     = RST_CLUSTER_LIMIT;
            cfg_threshold = RST_BAD_THRESHOLD;
            cfg_marker    = RST_END_MARKER;
            cfg_end_code  = RST_END_CODE_STORED;
            mismatches    = 0;
            results_seen  = 0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ENTRY_FORMAT:    cfg_format    = cfg_data[1:0];
                    CFG_FIRST_CLUSTER:   cfg_first     = cfg_data[15:0];
                    CFG_CLUSTER_LIMIT:   cfg_limit     = cfg_data[15:0];
                    CFG_BAD_THRESHOLD:   cfg_threshold = cfg_data[27:0];
                    CFG_END_MARKER:      cfg_marker    = cfg_data;
                    CFG_END_CODE_STORED: cfg_end_code  = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_failure($sformatf("result %0d: unexpected, read_value %h status %0d",
                                             results_seen, m_tdata, m_tuser));
                end else begin
                    oldest = expected_results.pop_front();
                    if (m_tdata !== oldest.value)
                        report_failure($sformatf("result %0d: read_value exp %h got %h",
                                                 results_seen, oldest.value, m_tdata));
                    if (m_tuser !== oldest.status)
                        report_failure($sformatf("result %0d: status exp %0d got %0d",
                                                 results_seen, oldest.status, m_tuser));
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(access_fat(op_e_t'(s_tuser), s_tdata[15:0],
                                                      s_tdata[31:16], s_tdata[63:32]));
        end
        outstanding = expected_results.size();
    end

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fea_pkg::*;

    localparam int STORE_BYTES  = 65536;
    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [63:0]          s_tdata;   // entry_index, raw_address, write_value
    logic [OP_W-1:0]      s_tuser;   // op
    logic                 m_tvalid;
    logic                 m_tready;
    logic [VAL_W-1:0]     m_tdata;   // read_value
    logic [STATUS_W-1:0]  m_tuser;   // status
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    int         mismatches;
    int         outstanding;
    int         quiet_cycles;
    idle_mode_t idle_mode;
    bit         hold_req;
    bit         hold_done;

    // stimulus-side copy of the settings that steer index choice
    logic [1:0]  fmt_now;
    logic [15:0] first_now;
    logic [15:0] limit_now;
    logic [27:0] thr_now;
    logic [31:0] marker_now;

    // nibbles of the store that hold defined data
    bit written_nib [0:2*STORE_BYTES-1];

    fat_entry_access #(.STORE_BYTES(STORE_BYTES)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fat_access_checker #(.STORE_BYTES(STORE_BYTES)) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // watchdog on cycles with no handshake at all
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                     || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stalls and one long hold-off on request
    initial begin
        hold_done = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if ((idle_mode == IDLE_RECV && $urandom_range(0, 99) < 81)
                         || (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 15)) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // first nibble and nibble count of an entry; returns 1 when it fits the store
    function automatic bit locate_entry(input logic [15:0] idx, output int nib0,
                                        output int nibs);
        int off;
        int len;
        case (fmt_now)
            FMT_12: begin
                off  = int'(idx) + int'(idx >> 1);
                len  = 2;
                nib0 = 2 * off + int'(idx[0]);
                nibs = 3;
            end
            FMT_16: begin
                off  = 2 * int'(idx);
                len  = 2;
                nib0 = 2 * off;
                nibs = 4;
            end
            default: begin
                off  = 4 * int'(idx);
                len  = 4;
                nib0 = 2 * off;
                nibs = 7;
            end
        endcase
        return off + len <= STORE_BYTES;
    endfunction

    // an entry read is allowed unless it would touch undefined store data
    function automatic bit entry_readable(input logic [15:0] idx);
        int nib0;
        int nibs;
        if (idx < first_now || idx >= limit_now) return 1'b1;
        if (!locate_entry(idx, nib0, nibs)) return 1'b1;
        for (int i = 0; i < nibs; i++)
            if (!written_nib[nib0 + i]) return 1'b0;
        return 1'b1;
    endfunction

    // one request on the input channel, entered and left at a falling edge
    task automatic issue(input op_e_t op, input logic [15:0] idx, input logic [15:0] addr,
                         input logic [31:0] wv);
        int nib0;
        int nibs;
        if (op == OP_WRITE_ENTRY && locate_entry(idx, nib0, nibs)) begin
            for (int i = 0; i < nibs; i++) written_nib[nib0 + i] = 1'b1;
        end
        if (op == OP_LOAD_BYTE) begin
            written_nib[2 * int'(addr)]     = 1'b1;
            written_nib[2 * int'(addr) + 1] = 1'b1;
        end
        while ((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 81)
               || (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 15)) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {wv, addr, idx};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 16'($urandom_range(0, 31));
        if (r < 70) begin
            // last entries that fit the store, and the first two that do not
            case (fmt_now)
                FMT_12:  return 16'(43686 + $urandom_range(0, 5));
                FMT_16:  return 16'(32764 + $urandom_range(0, 5));
                default: return 16'(16380 + $urandom_range(0, 5));
            endcase
        end
        if (r < 85) begin
            case ($urandom_range(0, 3))
                0:       return first_now - 16'd1;
                1:       return first_now;
                2:       return limit_now - 16'd1;
                default: return limit_now;
            endcase
        end
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return $urandom;
        if (r < 60) return 32'($urandom_range(0, 4095));
        if (r < 75) return {4'b0, thr_now} - 32'd2 + 32'($urandom_range(0, 4));
        if (r < 90) return marker_now;
        return 32'h0fff_fff0 | 32'($urandom_range(0, 15));
    endfunction

    task automatic issue_random();
        op_e_t       op;
        logic [15:0] idx;
        logic [15:0] addr;
        int          r;
        r    = $urandom_range(0, 99);
        op   = (r < 35) ? OP_READ_ENTRY : (r < 70) ? OP_WRITE_ENTRY :
               (r < 85) ? OP_LOAD_BYTE : OP_READ_BYTE;
        idx  = pick_index();
        addr = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 127)) : 16'($urandom);
        // never read data that was not written; write it instead
        if (op == OP_READ_ENTRY && !entry_readable(idx)) op = OP_WRITE_ENTRY;
        if (op == OP_READ_BYTE && !(written_nib[2 * int'(addr)]
                                    && written_nib[2 * int'(addr) + 1])) op = OP_LOAD_BYTE;
        issue(op, idx, addr, pick_value());
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // drain, reprogram all registers, then run random requests
    task automatic run_phase(input logic [1:0] fmt, input logic [15:0] first,
                             input logic [15:0] limit, input logic [27:0] thr,
                             input logic [31:0] marker, input logic [15:0] code,
                             input idle_mode_t mode, input int count, input bit hold);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
        idle_mode = IDLE_NONE;
        write_register(CFG_ENTRY_FORMAT, {30'b0, fmt});
        write_register(CFG_FIRST_CLUSTER, {16'b0, first});
        write_register(CFG_CLUSTER_LIMIT, {16'b0, limit});
        write_register(CFG_BAD_THRESHOLD, {4'b0, thr});
        write_register(CFG_END_MARKER, marker);
        write_register(CFG_END_CODE_STORED, {16'b0, code});
        cfg_valid  <= 1'b0;
        fmt_now    = fmt;
        first_now  = first;
        limit_now  = limit;
        thr_now    = thr;
        marker_now = marker;
        idle_mode  = mode;
        hold_req   = hold;
        repeat (count) issue_random();
    endtask

    initial begin
        idle_mode  = IDLE_NONE;
        hold_req   = 1'b0;
        fmt_now    = RST_ENTRY_FORMAT;
        first_now  = RST_FIRST_CLUSTER;
        limit_now  = RST_CLUSTER_LIMIT;
        thr_now    = RST_BAD_THRESHOLD;
        marker_now = RST_END_MARKER;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_READ_ENTRY;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_ENTRY_FORMAT;
        cfg_data  <= '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed requests under the reset settings (12 bit entries)
        issue(OP_LOAD_BYTE,   16'd0,     16'h0000, 32'hffff_ffa5);
        issue(OP_LOAD_BYTE,   16'd0,     16'hffff, 32'h0000_005a);
        issue(OP_READ_BYTE,   16'd0,     16'hffff, 32'h0);
        issue(OP_READ_BYTE,   16'd0,     16'h0000, 32'h0);
        issue(OP_WRITE_ENTRY, 16'd2,     16'h0000, 32'h0fff_ffff);
        issue(OP_WRITE_ENTRY, 16'd3,     16'h0000, 32'h0000_0abc);
        issue(OP_WRITE_ENTRY, 16'd4,     16'h0000, 32'hffff_f123);
        issue(OP_WRITE_ENTRY, 16'd5,     16'h0000, 32'h0000_0ff8);
        issue(OP_READ_ENTRY,  16'd2,     16'h0000, 32'h0);
        issue(OP_READ_ENTRY,  16'd3,     16'h0000, 32'h0);
        issue(OP_READ_ENTRY,  16'd4,     16'h0000, 32'h0);
        issue(OP_READ_ENTRY,  16'd5,     16'h0000, 32'h0);
        issue(OP_READ_BYTE,   16'd0,     16'h0004, 32'h0);
        issue(OP_READ_ENTRY,  16'd0,     16'h0000, 32'h0);
        issue(OP_READ_ENTRY,  16'd1,     16'h0000, 32'h0);
        issue(OP_READ_ENTRY,  16'hffff,  16'h0000, 32'h0);
        issue(OP_READ_ENTRY,  16'd43690, 16'h0000, 32'h0);
        issue(OP_WRITE_ENTRY, 16'd43690, 16'h0000, 32'h0000_0001);
        issue(OP_WRITE_ENTRY, 16'd43689, 16'h0000, 32'h0000_0800);
        issue(OP_READ_ENTRY,  16'd43689, 16'h0000, 32'h0);
        issue(OP_WRITE_ENTRY, 16'hffff,  16'h0000, 32'h0);
        issue(OP_WRITE_ENTRY, 16'd0,     16'h0000, 32'h0000_0ff0);
        issue(OP_READ_BYTE,   16'd0,     16'h0000, 32'h0);

        // random requests across formats, settings and idle patterns
        run_phase(FMT_12, 16'd2, 16'hffff, 28'd4087, 32'h0fff_ffff, 16'h0fff,
                  IDLE_NONE, 100, 1'b0);
        run_phase(FMT_16, 16'd0, 16'hffff, 28'h000_fff7, 32'h0000_ffff, 16'hffff,
                  IDLE_SEND, 100, 1'b0);
        run_phase(2'd2, 16'd2, 16'hffff, 28'h0ff_fff7, 32'h0fff_ffff, 16'h0000,
                  IDLE_RECV, 100, 1'b0);
        run_phase(2'd3, 16'd1, 16'd16384, 28'h0ff_ffff, 32'hffff_ffff, 16'h1234,
                  IDLE_BOTH, 100, 1'b0);
        run_phase(FMT_12, 16'd0, 16'd40, 28'd0, 32'h0000_0000, 16'habcd,
                  IDLE_NONE, 100, 1'b1);
        run_phase(FMT_16, 16'd16, 16'd32768, 28'h100, 32'h1234_5678, 16'h00ff,
                  IDLE_SEND, 100, 1'b0);
        run_phase(2'd2, 16'hffff, 16'd0, 28'h0ff_ffff, 32'h0fff_ffff, 16'h0fff,
                  IDLE_RECV, 60, 1'b0);
        run_phase(2'($urandom_range(0, 3)), 16'($urandom_range(0, 8)),
                  16'($urandom_range(16384, 65535)), 28'($urandom), $urandom,
                  16'($urandom), IDLE_BOTH, 100, 1'b0);

        // drain and give the verdict
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
